>>> sv/mih_pkg.sv
// shared constants, types and angle table of the magnetometer heading block
// no dependencies; imported by mih_heading and magnetometer_iron_heading
package mih_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COEF_BITS = 16;
   localparam int REG_BITS = 48;
   localparam int CSR_INDEX_BITS = 8;
   localparam int HEADING_BITS = 16;

   // cordic datapath
   localparam int CORDIC_STEPS = 20;
   localparam int XY_BITS = 32;
   localparam int Z_BITS = 25;
   localparam int NORM_POS = 28;
   localparam int HEAD_LAT = CORDIC_STEPS + 4;

   localparam logic signed [Z_BITS-1:0] HALF_TURN_Q8 = Z_BITS'(4608000);
   localparam logic signed [Z_BITS-1:0] ROUND_Q8 = Z_BITS'(128);
   localparam logic [HEADING_BITS:0] FULL_TURN = (HEADING_BITS + 1)'(36000);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_HARD_IRON = CSR_INDEX_BITS'(0),
      REG_SOFT_ROW_X = CSR_INDEX_BITS'(1),
      REG_SOFT_ROW_Y = CSR_INDEX_BITS'(2),
      REG_SOFT_ROW_Z = CSR_INDEX_BITS'(3)
   } reg_index_type;

   localparam logic [REG_BITS-1:0] HARD_RESET = REG_BITS'(0);
   localparam logic [REG_BITS-1:0] ROW_X_RESET = REG_BITS'(64'd4096);
   localparam logic [REG_BITS-1:0] ROW_Y_RESET = REG_BITS'(64'd4096 << 16);
   localparam logic [REG_BITS-1:0] ROW_Z_RESET = REG_BITS'(64'd4096 << 32);

   // atan(2^-i) in 1/256 of a hundredth degree
   function automatic logic signed [Z_BITS-1:0] atan_q8(input int step);
      logic signed [Z_BITS-1:0] v;
      unique case (step)
         0: v = Z_BITS'(1152000);
         1: v = Z_BITS'(680065);
         2: v = Z_BITS'(359328);
         3: v = Z_BITS'(182400);
         4: v = Z_BITS'(91554);
         5: v = Z_BITS'(45822);
         6: v = Z_BITS'(22916);
         7: v = Z_BITS'(11459);
         8: v = Z_BITS'(5730);
         9: v = Z_BITS'(2865);
         10: v = Z_BITS'(1432);
         11: v = Z_BITS'(716);
         12: v = Z_BITS'(358);
         13: v = Z_BITS'(179);
         14: v = Z_BITS'(90);
         15: v = Z_BITS'(45);
         16: v = Z_BITS'(22);
         17: v = Z_BITS'(11);
         18: v = Z_BITS'(6);
         19: v = Z_BITS'(3);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> sv/mih_heading.sv
// pipelined vectoring cordic: normalize, 20 rotation stages, round and mirror
// depends on mih_pkg; advances when en is high
module mih_heading #(
   parameter int W = 35
) (
   input logic clock,
   input logic en,
   input logic signed [W-1:0] vec_x,
   input logic signed [W-1:0] vec_y,
   output logic [mih_pkg::HEADING_BITS-1:0] heading
);
   import mih_pkg::*;

   localparam int SW = $clog2(W);

   // magnitude stage
   logic signed [W-1:0] x0_ff, y0_ff;
   logic [W-1:0] m0_ff, m0_in, ax, ay;
   logic zero0_ff;

   always_comb begin
      ax = vec_x[W-1] ? W'(-vec_x) : W'(vec_x);
      ay = vec_y[W-1] ? W'(-vec_y) : W'(vec_y);
      m0_in = (ax > ay) ? ax : ay;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff <= vec_x;
         y0_ff <= vec_y;
         m0_ff <= m0_in;
         zero0_ff <= (m0_in == '0);
      end
   end

   // leading one search
   logic signed [W-1:0] x1_ff, y1_ff;
   logic [SW-1:0] pos1_ff, pos1_in;
   logic zero1_ff;

   always_comb begin
      pos1_in = '0;
      for (int i = 0; i < W; i++) begin
         if (m0_ff[i]) pos1_in = SW'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= x0_ff;
         y1_ff <= y0_ff;
         pos1_ff <= pos1_in;
         zero1_ff <= zero0_ff;
      end
   end

   // scale to [2^28, 2^29) and fold the left half plane
   logic signed [XY_BITS-1:0] xi_ff [0:CORDIC_STEPS];
   logic signed [XY_BITS-1:0] yi_ff [0:CORDIC_STEPS];
   logic signed [Z_BITS-1:0] zi_ff [0:CORDIC_STEPS];
   logic zr_ff [0:CORDIC_STEPS];
   logic signed [XY_BITS-1:0] xn, yn, xs0_in, ys0_in;
   logic signed [Z_BITS-1:0] z0_in;
   logic signed [W-1:0] xr, yr;

   always_comb begin
      xr = x1_ff >>> (pos1_ff - SW'(NORM_POS));
      yr = y1_ff >>> (pos1_ff - SW'(NORM_POS));
      if (pos1_ff < SW'(NORM_POS)) begin
         xn = XY_BITS'(x1_ff) <<< (SW'(NORM_POS) - pos1_ff);
         yn = XY_BITS'(y1_ff) <<< (SW'(NORM_POS) - pos1_ff);
      end else begin
         xn = XY_BITS'(xr);
         yn = XY_BITS'(yr);
      end
      if (xn[XY_BITS-1]) begin
         xs0_in = -xn;
         ys0_in = -yn;
         z0_in = HALF_TURN_Q8;
      end else begin
         xs0_in = xn;
         ys0_in = yn;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xi_ff[0] <= xs0_in;
         yi_ff[0] <= ys0_in;
         zi_ff[0] <= z0_in;
         zr_ff[0] <= zero1_ff;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      logic signed [XY_BITS-1:0] x_in, y_in, xsh, ysh;
      logic signed [Z_BITS-1:0] z_in;

      always_comb begin
         xsh = xi_ff[i] >>> i;
         ysh = yi_ff[i] >>> i;
         if (yi_ff[i] > 0) begin
            x_in = xi_ff[i] + ysh;
            y_in = yi_ff[i] - xsh;
            z_in = zi_ff[i] + atan_q8(i);
         end else begin
            x_in = xi_ff[i] - ysh;
            y_in = yi_ff[i] + xsh;
            z_in = zi_ff[i] - atan_q8(i);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            xi_ff[i+1] <= x_in;
            yi_ff[i+1] <= y_in;
            zi_ff[i+1] <= z_in;
            zr_ff[i+1] <= zr_ff[i];
         end
      end
   end

   // round to hundredths, wrap to 0..35999, mirror
   logic signed [Z_BITS-1:0] zsum;
   logic signed [HEADING_BITS:0] adeg, awrap;
   logic [HEADING_BITS-1:0] heading_ff, heading_in;

   always_comb begin
      zsum = zi_ff[CORDIC_STEPS] + ROUND_Q8;
      adeg = (HEADING_BITS + 1)'(zsum >>> 8);
      awrap = adeg[HEADING_BITS] ? adeg + $signed(FULL_TURN) : adeg;
      if (zr_ff[CORDIC_STEPS] || awrap == '0) begin
         heading_in = '0;
      end else begin
         heading_in = HEADING_BITS'(FULL_TURN - unsigned'(awrap));
      end
   end

   always_ff @(posedge clock) begin
      if (en) heading_ff <= heading_in;
   end

   assign heading = heading_ff;

endmodule

>>> sv/magnetometer_iron_heading.sv
// top level of the magnetometer hard/soft-iron correction and heading block
// depends on mih_pkg and mih_heading
//
// Takes one raw three-axis magnetometer word per cycle on req_, subtracts the
// hard-iron offsets, applies the 3x3 soft-iron matrix (signed Q4.12) and
// returns on rsp_ three mirrored compass headings in hundredths of a degree
// (raw, hard-iron corrected, fully corrected) plus the corrected and raw axes
// realigned to the accelerometer frame (y, -x, -z). Throughput is one word per
// cycle; each word passes the input, offset, multiply and sum stages and then
// the 20-stage cordic with its normalize and round stages. The whole pipe
// advances whenever the output register is empty or being taken, so a stall on
// rsp_ freezes it without loss. The user writes registers on csr_ while idle;
// the block does not enforce it. Indexes beyond the list are ignored.
module magnetometer_iron_heading #(
   parameter int SAMPLE_BITS = mih_pkg::SAMPLE_BITS_DEF
) (
   input logic clock,
   input logic reset,
   // fields from bit 0: mag_x, mag_y, mag_z
   input logic [((3*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input logic req_tvalid,
   output logic req_tready,
   // fields from bit 0: raw_heading, hard_heading, soft_heading, cal_fwd,
   // cal_side, cal_down, raw_fwd, raw_side, raw_down
   output logic [((6*SAMPLE_BITS+50+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tvalid,
   input logic rsp_tready,
   input logic csr_valid,
   output logic csr_ready,
   input logic [mih_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [mih_pkg::REG_BITS-1:0] csr_wdata
);
   import mih_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int HW = ((SB > COEF_BITS) ? SB : COEF_BITS) + 1;  // offset-corrected axis
   localparam int PW = HW + COEF_BITS;                           // one product
   localparam int CW = PW + 2;                                   // sum of three products
   localparam int OUT_RAW = 3*HEADING_BITS + 4*SB + 2*(SB+1);
   localparam int OUT_W = ((6*SB+50+7)/8)*8;
   localparam int NV = 4 + HEAD_LAT;

   localparam logic signed [CW:0] SAT_HI = (CW+1)'((64'sd1 <<< (SB-1)) - 1);
   localparam logic signed [CW:0] SAT_LO = (CW+1)'(-(64'sd1 <<< (SB-1)));
   localparam logic signed [CW:0] RND_Q12 = (CW+1)'(2048);

   typedef struct packed {
      logic signed [SB:0] raw_down;
      logic signed [SB:0] raw_side;
      logic signed [SB-1:0] raw_fwd;
      logic signed [SB-1:0] cal_down;
      logic signed [SB-1:0] cal_side;
      logic signed [SB-1:0] cal_fwd;
   } side_type;

   // configuration registers
   logic [REG_BITS-1:0] hard_ff, row_x_ff, row_y_ff, row_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hard_ff <= HARD_RESET;
         row_x_ff <= ROW_X_RESET;
         row_y_ff <= ROW_Y_RESET;
         row_z_ff <= ROW_Z_RESET;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_HARD_IRON: hard_ff <= csr_wdata;
            REG_SOFT_ROW_X: row_x_ff <= csr_wdata;
            REG_SOFT_ROW_Y: row_y_ff <= csr_wdata;
            REG_SOFT_ROW_Z: row_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global advance: output register empty or being taken
   logic en;
   logic [NV-1:0] vld_ff;

   assign en = !vld_ff[NV-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NV-2:0], req_tvalid};
      end
   end

   // stage 1: input word
   logic signed [SB-1:0] rx1_ff, ry1_ff, rz1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rx1_ff <= req_tdata[SB-1:0];
         ry1_ff <= req_tdata[2*SB-1:SB];
         rz1_ff <= req_tdata[3*SB-1:2*SB];
      end
   end

   // stage 2: hard-iron subtraction
   logic signed [SB-1:0] rx2_ff, ry2_ff, rz2_ff;
   logic signed [HW-1:0] h2_ff [0:2];
   logic signed [HW-1:0] h2_in [0:2];
   logic signed [COEF_BITS-1:0] off [0:2];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         off[k] = hard_ff[k*COEF_BITS +: COEF_BITS];
      end
      h2_in[0] = HW'(rx1_ff) - HW'(off[0]);
      h2_in[1] = HW'(ry1_ff) - HW'(off[1]);
      h2_in[2] = HW'(rz1_ff) - HW'(off[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx2_ff <= rx1_ff;
         ry2_ff <= ry1_ff;
         rz2_ff <= rz1_ff;
         h2_ff <= h2_in;
      end
   end

   // stage 3: nine soft-iron products, row r by column c
   logic signed [SB-1:0] rx3_ff, ry3_ff, rz3_ff;
   logic signed [HW-1:0] hx3_ff, hy3_ff;
   logic signed [PW-1:0] p3_ff [0:2][0:2];
   logic signed [PW-1:0] p3_in [0:2][0:2];
   logic [REG_BITS-1:0] rows [0:2];
   logic signed [COEF_BITS-1:0] coef;

   always_comb begin
      rows[0] = row_x_ff;
      rows[1] = row_y_ff;
      rows[2] = row_z_ff;
      coef = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            coef = rows[r][c*COEF_BITS +: COEF_BITS];
            p3_in[r][c] = PW'(coef) * PW'(h2_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx3_ff <= rx2_ff;
         ry3_ff <= ry2_ff;
         rz3_ff <= rz2_ff;
         hx3_ff <= h2_ff[0];
         hy3_ff <= h2_ff[1];
         p3_ff <= p3_in;
      end
   end

   // stage 4: row sums, corrected axes in Q.12
   logic signed [SB-1:0] rx4_ff, ry4_ff, rz4_ff;
   logic signed [HW-1:0] hx4_ff, hy4_ff;
   logic signed [CW-1:0] c4_ff [0:2];
   logic signed [CW-1:0] c4_in [0:2];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         c4_in[r] = CW'(p3_ff[r][0]) + CW'(p3_ff[r][1]) + CW'(p3_ff[r][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx4_ff <= rx3_ff;
         ry4_ff <= ry3_ff;
         rz4_ff <= rz3_ff;
         hx4_ff <= hx3_ff;
         hy4_ff <= hy3_ff;
         c4_ff <= c4_in;
      end
   end

   // round half up to counts and saturate
   function automatic logic signed [SB-1:0] round_sat(input logic signed [CW:0] q12);
      logic signed [CW:0] t;
      logic signed [SB-1:0] r;
      t = (q12 + RND_Q12) >>> 12;
      if (t > SAT_HI) r = SB'(SAT_HI);
      else if (t < SAT_LO) r = SB'(SAT_LO);
      else r = SB'(t);
      return r;
   endfunction

   // aligned-frame axes ride a delay line beside the cordic pipes
   side_type side_in;
   side_type sd_ff [0:HEAD_LAT-1];

   always_comb begin
      side_in.cal_fwd = round_sat((CW+1)'(c4_ff[1]));
      side_in.cal_side = round_sat(-((CW+1)'(c4_ff[0])));
      side_in.cal_down = round_sat(-((CW+1)'(c4_ff[2])));
      side_in.raw_fwd = ry4_ff;
      side_in.raw_side = -((SB+1)'(rx4_ff));
      side_in.raw_down = -((SB+1)'(rz4_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= side_in;
         for (int k = 1; k < HEAD_LAT; k++) begin
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   // three heading pipes in lockstep
   logic [HEADING_BITS-1:0] raw_heading, hard_heading, soft_heading;

   mih_heading #(.W(CW)) u_raw_heading (
      .clock(clock),
      .en(en),
      .vec_x(CW'(rx4_ff)),
      .vec_y(CW'(ry4_ff)),
      .heading(raw_heading)
   );

   mih_heading #(.W(CW)) u_hard_heading (
      .clock(clock),
      .en(en),
      .vec_x(CW'(hx4_ff)),
      .vec_y(CW'(hy4_ff)),
      .heading(hard_heading)
   );

   mih_heading #(.W(CW)) u_soft_heading (
      .clock(clock),
      .en(en),
      .vec_x(c4_ff[0]),
      .vec_y(c4_ff[1]),
      .heading(soft_heading)
   );

   // result word, zero padded to whole bytes
   logic [OUT_RAW-1:0] rsp_body;

   assign rsp_body = {sd_ff[HEAD_LAT-1], soft_heading, hard_heading, raw_heading};
   assign rsp_tdata = OUT_W'(rsp_body);
   assign rsp_tvalid = vld_ff[NV-1];

endmodule
